// ===== rtl/tvg_pkg.sv =====
// ----------------------------------------------------------------------------
// tvg_pkg
// Types, constants and rounding helpers shared by the torus vertex pipeline.
// ----------------------------------------------------------------------------
package tvg_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int IDX_W        = 9;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO    = 4'd0,
    CFG_SEGMENTS = 4'd1,
    CFG_TEX_SX   = 4'd2,
    CFG_TEX_SY   = 4'd3
  } cfg_reg_t;

  localparam logic [15:0] RATIO_RST    = 16'd768;
  localparam logic [15:0] RATIO_ONE    = 16'd256;
  localparam logic [8:0]  SEGMENTS_RST = 9'd32;
  localparam logic [15:0] TEX_SX_RST   = 16'd256;
  localparam logic [15:0] TEX_SY_RST   = 16'd256;

  // Q30 constants
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'd1073741824;
  // 2^38 split as remainder seed and low dividend word for the reciprocal
  localparam logic [15:0] RECIP_SEED  = 16'd64;

  // Long division: quotient bits and bits resolved per stage
  localparam int DIV_QW     = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_QW / DIV_STEP;

  // Sine/cosine: Taylor terms, three stages each, plus angle, square, fold
  localparam int SC_TERMS = 10;
  localparam int SC_W     = 34;
  localparam int SC_LAT   = 2 + 3 * SC_TERMS + 1;

  localparam int PREP_LAT = 1;
  localparam int SH_LAT   = 4;
  localparam int TEX_LAT  = 1;
  localparam int LAT      = PREP_LAT + DIV_STAGES + SC_LAT + SH_LAT;

  typedef struct packed {
    logic [IDX_W-1:0] tube_index;
    logic [IDX_W-1:0] sweep_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
  } geo_t;

  typedef struct packed {
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } tex_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic               bad_ratio;
  } out_item_t;

  // Shift right with round to nearest, ties away from zero
  function automatic logic signed [69:0] rnd_shift(input logic signed [69:0] v,
                                                   input int unsigned sh);
    logic [69:0] m;
    m = v[69] ? 70'(-v) : 70'(v);
    m = (m + (70'd1 << (sh - 1))) >> sh;
    return v[69] ? -signed'(m) : signed'(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [69:0] v);
    logic signed [15:0] r;
    if (v > 70'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -70'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/tvg_div.sv =====
// ----------------------------------------------------------------------------
// tvg_div
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
// ----------------------------------------------------------------------------
module tvg_div
  import tvg_pkg::*;
#(
  parameter int DW = 9
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DW-1:0]     rem0,
  input  logic [DIV_QW-1:0] num_lo,
  input  logic [DW-1:0]     den,
  output logic [DIV_QW-1:0] quo
);

  logic [DW-1:0]     rem_r   [DIV_STAGES];
  logic [DW-1:0]     rem_nxt [DIV_STAGES];
  logic [DIV_QW-1:0] lo_r    [DIV_STAGES];
  logic [DIV_QW-1:0] lo_nxt  [DIV_STAGES];
  logic [DIV_QW-1:0] q_r     [DIV_STAGES];
  logic [DIV_QW-1:0] q_nxt   [DIV_STAGES];

  always_comb begin
    logic [DW-1:0]     rem;
    logic [DIV_QW-1:0] lo;
    logic [DIV_QW-1:0] q;
    logic [DW:0]       t;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem = rem0;
        lo  = num_lo;
        q   = '0;
      end else begin
        rem = rem_r[s-1];
        lo  = lo_r[s-1];
        q   = q_r[s-1];
      end
      for (int b = 0; b < DIV_STEP; b++) begin
        t  = {rem, lo[DIV_QW-1]};
        lo = {lo[DIV_QW-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
          rem = DW'(t - {1'b0, den});
          q   = {q[DIV_QW-2:0], 1'b1};
        end else begin
          rem = t[DW-1:0];
          q   = {q[DIV_QW-2:0], 1'b0};
        end
      end
      rem_nxt[s] = rem;
      lo_nxt[s]  = lo;
      q_nxt[s]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

// ===== rtl/tvg_sincos.sv =====
// ----------------------------------------------------------------------------
// tvg_sincos
// Q30 sine and cosine of a turn fraction: Taylor series, one term per
// three stages, then quadrant fold.
// ----------------------------------------------------------------------------
module tvg_sincos
  import tvg_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            phase,
  output logic signed [SC_W-1:0] sin_q,
  output logic signed [SC_W-1:0] cos_q
);

  logic [60:0] px;
  logic [31:0] x_r;
  logic [1:0]  quad0_r;
  logic [63:0] sq;

  // Term boundaries: index 0 seeds the series, index k holds term k
  logic [31:0]            bd_ts_r   [SC_TERMS+1];
  logic [31:0]            bd_tc_r   [SC_TERMS+1];
  logic [31:0]            bd_x2_r   [SC_TERMS+1];
  logic signed [SC_W-1:0] bd_ss_r   [SC_TERMS+1];
  logic signed [SC_W-1:0] bd_cc_r   [SC_TERMS+1];
  logic [1:0]             bd_quad_r [SC_TERMS+1];

  logic signed [SC_W-1:0] sin_r;
  logic signed [SC_W-1:0] cos_r;

  assign px = phase[29:0] * PI_HALF_Q30;
  assign sq = x_r * x_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r          <= {1'b0, px[60:30]};
      quad0_r      <= phase[31:30];
      bd_x2_r[0]   <= sq[61:30];
      bd_ts_r[0]   <= x_r;
      bd_tc_r[0]   <= ONE_Q30;
      bd_ss_r[0]   <= signed'(SC_W'(x_r));
      bd_cc_r[0]   <= signed'(SC_W'(ONE_Q30));
      bd_quad_r[0] <= quad0_r;
    end
  end

  for (genvar k = 1; k <= SC_TERMS; k++) begin : g_term
    localparam int DS = 2 * k * (2 * k + 1);
    localparam int DC = (2 * k - 1) * (2 * k);
    localparam int SHS = 31 + $clog2(DS);
    localparam int SHC = 31 + $clog2(DC);
    localparam logic [31:0] MS = 32'((64'd1 << SHS) / DS);
    localparam logic [31:0] MC = 32'((64'd1 << SHC) / DC);
    localparam bit SUB = (k % 2) == 1;

    logic [63:0]            ps;
    logic [63:0]            pc;
    logic [31:0]            a_ns_r, a_nc_r, a_x2_r;
    logic signed [SC_W-1:0] a_ss_r, a_cc_r;
    logic [1:0]             a_quad_r;
    logic [63:0]            b_ms_r, b_mc_r;
    logic [31:0]            b_ns_r, b_nc_r, b_x2_r;
    logic signed [SC_W-1:0] b_ss_r, b_cc_r;
    logic [1:0]             b_quad_r;
    logic [31:0]            q0s, q0c, rems, remc, qs, qc;

    assign ps = bd_ts_r[k-1] * bd_x2_r[k-1];
    assign pc = bd_tc_r[k-1] * bd_x2_r[k-1];

    // Floor division by the term constant: reciprocal, then one correction
    assign q0s  = 32'(b_ms_r >> SHS);
    assign q0c  = 32'(b_mc_r >> SHC);
    assign rems = b_ns_r - 32'(q0s * 32'(DS));
    assign remc = b_nc_r - 32'(q0c * 32'(DC));
    assign qs   = (rems >= 32'(DS)) ? q0s + 32'd1 : q0s;
    assign qc   = (remc >= 32'(DC)) ? q0c + 32'd1 : q0c;

    always_ff @(posedge clk) begin
      if (en) begin
        a_ns_r   <= ps[61:30];
        a_nc_r   <= pc[61:30];
        a_x2_r   <= bd_x2_r[k-1];
        a_ss_r   <= bd_ss_r[k-1];
        a_cc_r   <= bd_cc_r[k-1];
        a_quad_r <= bd_quad_r[k-1];

        b_ms_r   <= a_ns_r * MS;
        b_mc_r   <= a_nc_r * MC;
        b_ns_r   <= a_ns_r;
        b_nc_r   <= a_nc_r;
        b_x2_r   <= a_x2_r;
        b_ss_r   <= a_ss_r;
        b_cc_r   <= a_cc_r;
        b_quad_r <= a_quad_r;

        bd_ts_r[k]   <= qs;
        bd_tc_r[k]   <= qc;
        bd_x2_r[k]   <= b_x2_r;
        bd_quad_r[k] <= b_quad_r;
        if (SUB) begin
          bd_ss_r[k] <= b_ss_r - signed'(SC_W'(qs));
          bd_cc_r[k] <= b_cc_r - signed'(SC_W'(qc));
        end else begin
          bd_ss_r[k] <= b_ss_r + signed'(SC_W'(qs));
          bd_cc_r[k] <= b_cc_r + signed'(SC_W'(qc));
        end
      end
    end
  end

  // Fold the first-quadrant result into the full turn
  always_ff @(posedge clk) begin
    if (en) begin
      case (bd_quad_r[SC_TERMS])
        2'd0: begin
          sin_r <= bd_ss_r[SC_TERMS];
          cos_r <= bd_cc_r[SC_TERMS];
        end
        2'd1: begin
          sin_r <= bd_cc_r[SC_TERMS];
          cos_r <= -bd_ss_r[SC_TERMS];
        end
        2'd2: begin
          sin_r <= -bd_ss_r[SC_TERMS];
          cos_r <= -bd_cc_r[SC_TERMS];
        end
        default: begin
          sin_r <= -bd_cc_r[SC_TERMS];
          cos_r <= bd_ss_r[SC_TERMS];
        end
      endcase
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

// ===== rtl/tvg_shade.sv =====
// ----------------------------------------------------------------------------
// tvg_shade
// Position, normal and tangent from the two angles, four stages.
// ----------------------------------------------------------------------------
module tvg_shade
  import tvg_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [SC_W-1:0] sfi,
  input  logic signed [SC_W-1:0] cfi,
  input  logic signed [SC_W-1:0] sth,
  input  logic signed [SC_W-1:0] cth,
  input  logic signed [31:0]     rr,
  output geo_t                   geo
);

  logic signed [65:0]     rc_r, prs_r;
  logic signed [67:0]     pcc_r, pcs_r, psc_r, pss_r;
  logic signed [SC_W-1:0] sfi1_r, cfi1_r, sth1_r, cth1_r;
  logic signed [31:0]     rr1_r;
  logic signed [69:0]     a_full;
  logic signed [SC_W-1:0] a_r, sth2_r, cth2_r;
  geo_t                   g2_r, g3_r, geo_r;
  logic signed [67:0]     pac_r, pas_r;

  assign a_full = 70'(signed'(ONE_Q30)) - 70'(rr1_r) + rnd_shift(70'(rc_r), 30);

  always_ff @(posedge clk) begin
    if (en) begin
      // products
      rc_r   <= rr * cfi;
      prs_r  <= rr * sfi;
      pcc_r  <= cfi * cth;
      pcs_r  <= cfi * sth;
      psc_r  <= sfi * cth;
      pss_r  <= sfi * sth;
      sfi1_r <= sfi;
      cfi1_r <= cfi;
      sth1_r <= sth;
      cth1_r <= cth;
      rr1_r  <= rr;

      // radial term and the outputs that are ready now
      a_r            <= a_full[SC_W-1:0];
      sth2_r         <= sth1_r;
      cth2_r         <= cth1_r;
      g2_r.pos_x     <= '0;
      g2_r.pos_y     <= '0;
      g2_r.pos_z     <= sat16(rnd_shift(70'(prs_r), 46));
      g2_r.normal_x  <= sat16(rnd_shift(70'(pcc_r), 45));
      g2_r.normal_y  <= sat16(rnd_shift(70'(pcs_r), 45));
      g2_r.normal_z  <= sat16(rnd_shift(70'(sfi1_r), 15));
      g2_r.tangent_x <= sat16(rnd_shift(-(70'(psc_r)), 45));
      g2_r.tangent_y <= sat16(rnd_shift(-(70'(pss_r)), 45));
      g2_r.tangent_z <= sat16(rnd_shift(70'(cfi1_r), 15));

      pac_r <= a_r * cth2_r;
      pas_r <= a_r * sth2_r;
      g3_r  <= g2_r;

      geo_r.pos_x     <= sat16(rnd_shift(70'(pac_r), 46));
      geo_r.pos_y     <= sat16(rnd_shift(70'(pas_r), 46));
      geo_r.pos_z     <= g3_r.pos_z;
      geo_r.normal_x  <= g3_r.normal_x;
      geo_r.normal_y  <= g3_r.normal_y;
      geo_r.normal_z  <= g3_r.normal_z;
      geo_r.tangent_x <= g3_r.tangent_x;
      geo_r.tangent_y <= g3_r.tangent_y;
      geo_r.tangent_z <= g3_r.tangent_z;
    end
  end

  assign geo = geo_r;

endmodule

// ===== rtl/torus_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// torus_vertex_generator
// Torus mesh vertex: position, normal, tangent and texture from a grid point.
// ----------------------------------------------------------------------------
// Stages from an accepted transaction to its result: 1 prep, 8 divider,
//   33 sine/cosine, 4 shading.
// Throughput: one vertex per cycle; a stall on the result side freezes the
//   whole pipeline, so nothing is dropped or repeated.
// Reset: rst_n is synchronous, active low; it empties the pipeline and loads
//   ratio 3.0, 32 segments and unit texture scales.
// ----------------------------------------------------------------------------
module torus_vertex_generator
  import tvg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RR_DLY  = SC_LAT;
  localparam int TEX_DLY = SC_LAT + SH_LAT - TEX_LAT;

  // Configuration registers
  logic [15:0] ratio_r;
  logic [8:0]  segments_r;
  logic [15:0] tex_sx_r;
  logic [15:0] tex_sy_r;

  // Derived configuration
  logic [8:0]  p_eff;
  logic        bad;
  logic [15:0] rat_eff;

  logic en;
  logic vld_r [LAT];

  // Prep stage
  logic [8:0]         ic, jc;
  logic signed [25:0] pu, pv;
  logic [25:0]        mu, mv;
  logic [8:0]         rem_i_r, rem_j_r;
  logic [23:0]        mu_r, mv_r;
  logic               neg_u_r [DIV_STAGES+1];
  logic               neg_v_r [DIV_STAGES+1];

  // Divider outputs
  logic [DIV_QW-1:0] ph_i, ph_j, rr_q, qu, qv;

  // Texture
  logic signed [26:0] su, sv;
  tex_t               tex_r [TEX_DLY+1];

  logic signed [31:0]     rr_r [RR_DLY];
  logic signed [SC_W-1:0] sfi, cfi, sth, cth;
  geo_t                   geo;

  // Stall the input whenever a finished result is held back
  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Accept register writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r    <= RATIO_RST;
      segments_r <= SEGMENTS_RST;
      tex_sx_r   <= TEX_SX_RST;
      tex_sy_r   <= TEX_SY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RATIO:    ratio_r    <= cfg_data;
        CFG_SEGMENTS: segments_r <= cfg_data[8:0];
        CFG_TEX_SX:   tex_sx_r   <= cfg_data;
        CFG_TEX_SY:   tex_sy_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the segment count and swap a ratio below one for 3.0
  always_comb begin
    if (segments_r == 9'd0) begin
      p_eff = 9'd1;
    end else if (segments_r > 9'(MAX_SEGMENTS)) begin
      p_eff = 9'(MAX_SEGMENTS);
    end else begin
      p_eff = segments_r;
    end
  end
  assign bad     = ratio_r < RATIO_ONE;
  assign rat_eff = bad ? RATIO_RST : ratio_r;

  // Valid bits travel with the data and advance only with the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < LAT; n++) vld_r[n] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int n = 1; n < LAT; n++) vld_r[n] <= vld_r[n-1];
    end
  end

  // Prep: clamp indexes, seed the phase dividers, form texture dividends.
  // An index equal to p is a full turn, which wraps to phase zero.
  assign ic = (in_data.tube_index > p_eff) ? p_eff : in_data.tube_index;
  assign jc = (in_data.sweep_index > p_eff) ? p_eff : in_data.sweep_index;
  assign pu = signed'({1'b0, ic}) * signed'(tex_sx_r);
  assign pv = signed'({1'b0, jc}) * signed'(tex_sy_r);
  assign mu = (pu[25] ? 26'(-pu) : 26'(pu)) + 26'(p_eff[8:1]);
  assign mv = (pv[25] ? 26'(-pv) : 26'(pv)) + 26'(p_eff[8:1]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_i_r    <= (ic == p_eff) ? 9'd0 : ic;
      rem_j_r    <= (jc == p_eff) ? 9'd0 : jc;
      mu_r       <= mu[23:0];
      mv_r       <= mv[23:0];
      neg_u_r[0] <= pu[25];
      neg_v_r[0] <= pv[25];
      for (int n = 1; n <= DIV_STAGES; n++) begin
        neg_u_r[n] <= neg_u_r[n-1];
        neg_v_r[n] <= neg_v_r[n-1];
      end
    end
  end

  // Phase = round(index * 2^32 / p), reciprocal = round(2^38 / ratio),
  // texture = round(|index * scale| / p); all use tvg_div, the reciprocal 16 bits wide
  tvg_div #(.DW(9)) u_div_tube (
    .clk(clk), .en(en), .rem0(rem_i_r), .num_lo(32'(p_eff[8:1])),
    .den(p_eff), .quo(ph_i)
  );

  tvg_div #(.DW(9)) u_div_sweep (
    .clk(clk), .en(en), .rem0(rem_j_r), .num_lo(32'(p_eff[8:1])),
    .den(p_eff), .quo(ph_j)
  );

  tvg_div #(.DW(16)) u_div_recip (
    .clk(clk), .en(en), .rem0(RECIP_SEED), .num_lo(32'(rat_eff[15:1])),
    .den(rat_eff), .quo(rr_q)
  );

  tvg_div #(.DW(9)) u_div_tex_u (
    .clk(clk), .en(en), .rem0(9'd0), .num_lo(32'(mu_r)), .den(p_eff), .quo(qu)
  );

  tvg_div #(.DW(9)) u_div_tex_v (
    .clk(clk), .en(en), .rem0(9'd0), .num_lo(32'(mv_r)), .den(p_eff), .quo(qv)
  );

  // Texture: restore the sign, v counts down from the scale
  assign su = neg_u_r[DIV_STAGES] ? -signed'({2'b0, qu[24:0]})
                                  : signed'({2'b0, qu[24:0]});
  assign sv = signed'(27'(signed'(tex_sy_r)))
            - (neg_v_r[DIV_STAGES] ? -signed'({2'b0, qv[24:0]})
                                   : signed'({2'b0, qv[24:0]}));

  // Hold texture and reciprocal until the geometry catches up
  always_ff @(posedge clk) begin
    if (en) begin
      tex_r[0].tex_u <= sat16(70'(su));
      tex_r[0].tex_v <= sat16(70'(sv));
      for (int n = 1; n <= TEX_DLY; n++) tex_r[n] <= tex_r[n-1];
      rr_r[0] <= signed'({1'b0, rr_q[30:0]});
      for (int n = 1; n < RR_DLY; n++) rr_r[n] <= rr_r[n-1];
    end
  end

  tvg_sincos u_sc_tube (
    .clk(clk), .en(en), .phase(ph_i), .sin_q(sfi), .cos_q(cfi)
  );

  tvg_sincos u_sc_sweep (
    .clk(clk), .en(en), .phase(ph_j), .sin_q(sth), .cos_q(cth)
  );

  tvg_shade u_shade (
    .clk(clk), .en(en), .sfi(sfi), .cfi(cfi), .sth(sth), .cth(cth),
    .rr(rr_r[RR_DLY-1]), .geo(geo)
  );

  // Result transaction; the ratio flag follows the registers, which the user
  // must keep put while anything is in flight; the block does not enforce it
  assign out_valid = vld_r[LAT-1];

  always_comb begin
    out_data.pos_x     = geo.pos_x;
    out_data.pos_y     = geo.pos_y;
    out_data.pos_z     = geo.pos_z;
    out_data.normal_x  = geo.normal_x;
    out_data.normal_y  = geo.normal_y;
    out_data.normal_z  = geo.normal_z;
    out_data.tangent_x = geo.tangent_x;
    out_data.tangent_y = geo.tangent_y;
    out_data.tangent_z = geo.tangent_z;
    out_data.tex_u     = tex_r[TEX_DLY].tex_u;
    out_data.tex_v     = tex_r[TEX_DLY].tex_v;
    out_data.bad_ratio = bad;
  end

endmodule
